// File: src/rotate_vector_about_axis_core_defines.svh
// Assertion macros for the rotate_vector_about_axis_core block.
// No dependencies; included by files that carry assertions.
`ifndef ROTATE_VECTOR_ABOUT_AXIS_CORE_DEFINES_SVH
`define ROTATE_VECTOR_ABOUT_AXIS_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define RVAA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rvaa assertion failed");
`define RVAA_ASSERT_NXT(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("rvaa assertion failed");
`else
`define RVAA_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define RVAA_ASSERT_NXT(lbl, clk, ante, cons)
`endif
`endif

// File: src/rvaa_pkg.sv
// Shared types, constants and the CORDIC angle table for the rotation block.
// No dependencies.
`timescale 1ns / 1ps
package rvaa_pkg;
    localparam int VecW   = 24;
    localparam int AxisW  = 18;
    localparam int AngW   = 16;
    localparam int ZW     = 32;
    localparam int TabLen = 24;
    localparam longint GainQ30 = 64'sd652032874;

    typedef struct packed {
        logic signed [VecW-1:0]  vec_x;
        logic signed [VecW-1:0]  vec_y;
        logic signed [VecW-1:0]  vec_z;
        logic signed [AxisW-1:0] axis_x;
        logic signed [AxisW-1:0] axis_y;
        logic signed [AxisW-1:0] axis_z;
    } t_geom;

    function automatic logic [ZW-1:0] atan_turn(input int idx);
        logic [ZW-1:0] v;
        case (idx)
            0:  v = 32'h20000000;
            1:  v = 32'h12E4051E;
            2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;
            4:  v = 32'h028B0D43;
            5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;
            7:  v = 32'h00517C55;
            8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;
            10: v = 32'h000A2F98;
            11: v = 32'h000517CC;
            12: v = 32'h00028BE6;
            13: v = 32'h000145F3;
            14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;
            16: v = 32'h000028BE;
            17: v = 32'h0000145F;
            18: v = 32'h00000A30;
            19: v = 32'h00000518;
            20: v = 32'h0000028C;
            21: v = 32'h00000146;
            22: v = 32'h000000A3;
            23: v = 32'h00000051;
            default: v = '0;
        endcase
        return v;
    endfunction
endpackage

// File: src/rvaa_cordic_cell.sv
// One rotation-mode CORDIC micro-rotation cell; carries the geometry alongside.
// Depends on rvaa_pkg.
`timescale 1ns / 1ps
module rvaa_cordic_cell #(
    parameter int SHIFT = 0,
    parameter int XW    = 18
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  logic signed [XW-1:0]          i_x,
    input  logic signed [XW-1:0]          i_y,
    input  logic signed [rvaa_pkg::ZW-1:0] i_z,
    input  logic [1:0]                    i_quad,
    input  rvaa_pkg::t_geom               i_geom,
    output logic                          o_valid,
    output logic signed [XW-1:0]          o_x,
    output logic signed [XW-1:0]          o_y,
    output logic signed [rvaa_pkg::ZW-1:0] o_z,
    output logic [1:0]                    o_quad,
    output rvaa_pkg::t_geom               o_geom
);
    import rvaa_pkg::*;

    localparam logic signed [ZW-1:0] Atan = atan_turn(SHIFT);

    logic                  r_valid;
    logic signed [XW-1:0]  r_x, r_y, n_x, n_y;
    logic signed [ZW-1:0]  r_z, n_z;
    logic [1:0]            r_quad;
    t_geom                 r_geom;

    always_comb begin
        if (i_z >= 0) begin
            n_x = i_x - (i_y >>> SHIFT);
            n_y = i_y + (i_x >>> SHIFT);
            n_z = i_z - Atan;
        end else begin
            n_x = i_x + (i_y >>> SHIFT);
            n_y = i_y - (i_x >>> SHIFT);
            n_z = i_z + Atan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
        if (i_en) begin
            r_x    <= n_x;
            r_y    <= n_y;
            r_z    <= n_z;
            r_quad <= i_quad;
            r_geom <= i_geom;
        end
    end

    assign o_valid = r_valid;
    assign o_x     = r_x;
    assign o_y     = r_y;
    assign o_z     = r_z;
    assign o_quad  = r_quad;
    assign o_geom  = r_geom;
endmodule

// File: src/rvaa_math.sv
// Rodrigues combine pipeline: quadrant map, cross/dot products, projection,
// weighted sum, rounding and saturation. Depends on rvaa_pkg.
`timescale 1ns / 1ps
module rvaa_math #(
    parameter int FRAC_BITS = 16,
    parameter int XW        = 18
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_en,
    input  logic                            i_valid,
    input  logic signed [XW-1:0]            i_x,
    input  logic signed [XW-1:0]            i_y,
    input  logic [1:0]                      i_quad,
    input  rvaa_pkg::t_geom                 i_geom,
    output logic                            o_valid,
    output logic signed [rvaa_pkg::VecW-1:0] o_rot_x,
    output logic signed [rvaa_pkg::VecW-1:0] o_rot_y,
    output logic signed [rvaa_pkg::VecW-1:0] o_rot_z,
    output logic                            o_saturated
);
    import rvaa_pkg::*;

    localparam int PW  = VecW + AxisW;      // a*v product
    localparam int CRW = PW + 2 - 16;       // rounded cross/dot
    localparam int PPW = CRW + AxisW;       // dot*a
    localparam int PJW = PPW + 1 - 16;      // rounded projection
    localparam int OW  = FRAC_BITS + 3;     // 1 - cos
    localparam int SW  = FRAC_BITS + PJW + 5;
    localparam int RW  = SW - FRAC_BITS;
    localparam logic signed [RW-1:0] VMax = RW'(64'sd8388607);
    localparam logic signed [RW-1:0] VMin = RW'(-64'sd8388608);
    localparam logic signed [OW-1:0] One  = OW'(64'sd1 <<< FRAC_BITS);
    localparam logic signed [SW-1:0] Half = SW'(64'sd1 <<< (FRAC_BITS - 1));

    logic [5:0] r_vld;

    // stage 1
    logic signed [XW-1:0] r1_c, r1_s, n_c, n_s;
    logic signed [PW-1:0] r1_p [9];
    t_geom                r1_g;
    // stage 2
    logic signed [XW-1:0]  r2_c, r2_s;
    logic signed [CRW-1:0] r2_cr [3];
    logic signed [CRW-1:0] r2_dot;
    t_geom                 r2_g;
    // stage 3
    logic signed [XW-1:0]  r3_c, r3_s;
    logic signed [OW-1:0]  r3_omc;
    logic signed [CRW-1:0] r3_cr [3];
    logic signed [PPW-1:0] r3_pp [3];
    t_geom                 r3_g;
    // stage 4
    logic signed [XW-1:0]  r4_c, r4_s;
    logic signed [OW-1:0]  r4_omc;
    logic signed [CRW-1:0] r4_cr [3];
    logic signed [PJW-1:0] r4_pj [3];
    t_geom                 r4_g;
    // stage 5
    logic signed [SW-1:0]  r5_t [3][3];
    // stage 6
    logic signed [VecW-1:0] r6_rot [3];
    logic                   r6_sat;

    logic signed [VecW-1:0]  v [3], v4 [3];
    logic signed [AxisW-1:0] a [3], a2 [3];
    logic signed [PW+1:0]    d [3];
    logic signed [PW+1:0]    dsum;
    logic signed [PPW:0]     pr [3];
    logic signed [SW-1:0]    tot [3];
    logic signed [RW-1:0]    rr [3];
    logic signed [VecW-1:0]  n_rot [3];
    logic [2:0]              n_satk;

    always_comb begin
        case (i_quad)
            2'd0: begin n_c = i_x;  n_s = i_y;  end
            2'd1: begin n_c = -i_y; n_s = i_x;  end
            2'd2: begin n_c = -i_x; n_s = -i_y; end
            default: begin n_c = i_y; n_s = -i_x; end
        endcase
        v[0] = i_geom.vec_x;  v[1] = i_geom.vec_y;  v[2] = i_geom.vec_z;
        a[0] = i_geom.axis_x; a[1] = i_geom.axis_y; a[2] = i_geom.axis_z;
        a2[0] = r2_g.axis_x;  a2[1] = r2_g.axis_y;  a2[2] = r2_g.axis_z;
        v4[0] = r4_g.vec_x;   v4[1] = r4_g.vec_y;   v4[2] = r4_g.vec_z;
        // products: 0..5 cross terms, 6..8 dot terms
        d[0] = (PW+2)'(r1_p[0]) - (PW+2)'(r1_p[1]) + (PW+2)'(32768);
        d[1] = (PW+2)'(r1_p[2]) - (PW+2)'(r1_p[3]) + (PW+2)'(32768);
        d[2] = (PW+2)'(r1_p[4]) - (PW+2)'(r1_p[5]) + (PW+2)'(32768);
        dsum = (PW+2)'(r1_p[6]) + (PW+2)'(r1_p[7]) + (PW+2)'(r1_p[8])
             + (PW+2)'(32768);
        for (int k = 0; k < 3; k++) begin
            pr[k]   = (PPW+1)'(r3_pp[k]) + (PPW+1)'(32768);
            tot[k]  = r5_t[k][0] + r5_t[k][1] + r5_t[k][2] + Half;
            rr[k]   = tot[k][SW-1:FRAC_BITS];
            n_satk[k] = (rr[k] > VMax) || (rr[k] < VMin);
            if (rr[k] > VMax) begin
                n_rot[k] = VecW'(VMax);
            end else if (rr[k] < VMin) begin
                n_rot[k] = VecW'(VMin);
            end else begin
                n_rot[k] = rr[k][VecW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_en) begin
            r_vld <= {r_vld[4:0], i_valid};
        end
        if (i_en) begin
            r1_c <= n_c;
            r1_s <= n_s;
            r1_p[0] <= a[1] * v[2];
            r1_p[1] <= a[2] * v[1];
            r1_p[2] <= a[2] * v[0];
            r1_p[3] <= a[0] * v[2];
            r1_p[4] <= a[0] * v[1];
            r1_p[5] <= a[1] * v[0];
            r1_p[6] <= a[0] * v[0];
            r1_p[7] <= a[1] * v[1];
            r1_p[8] <= a[2] * v[2];
            r1_g <= i_geom;

            r2_c <= r1_c;
            r2_s <= r1_s;
            for (int k = 0; k < 3; k++) begin
                r2_cr[k] <= d[k][PW+1:16];
            end
            r2_dot <= dsum[PW+1:16];
            r2_g   <= r1_g;

            r3_c   <= r2_c;
            r3_s   <= r2_s;
            r3_omc <= One - OW'(r2_c);
            for (int k = 0; k < 3; k++) begin
                r3_cr[k] <= r2_cr[k];
                r3_pp[k] <= r2_dot * a2[k];
            end
            r3_g <= r2_g;

            r4_c   <= r3_c;
            r4_s   <= r3_s;
            r4_omc <= r3_omc;
            for (int k = 0; k < 3; k++) begin
                r4_cr[k] <= r3_cr[k];
                r4_pj[k] <= pr[k][PPW:16];
            end
            r4_g <= r3_g;

            for (int k = 0; k < 3; k++) begin
                r5_t[k][0] <= SW'(r4_c * v4[k]);
                r5_t[k][1] <= SW'(r4_s * r4_cr[k]);
                r5_t[k][2] <= SW'(r4_omc * r4_pj[k]);
            end

            for (int k = 0; k < 3; k++) begin
                r6_rot[k] <= n_rot[k];
            end
            r6_sat <= |n_satk;
        end
    end

    assign o_valid     = r_vld[5];
    assign o_rot_x     = r6_rot[0];
    assign o_rot_y     = r6_rot[1];
    assign o_rot_z     = r6_rot[2];
    assign o_saturated = r6_sat;
endmodule

// File: src/rotate_vector_about_axis_core.sv
// Top level: Rodrigues vector rotation, CORDIC cell chain plus combine pipeline.
// Depends on rvaa_pkg, rvaa_cordic_cell, rvaa_math and the defines header.
//
// channel | dir | tdata                                   | tuser
// s_axis  | in  | vec_x,y,z (24b each), axis_x,y,z (18b), | -
//         |     | turn_angle (16b), zero pad to 144b      |
// m_axis  | out | rot_x,y,z (24b each), 72b               | saturated
//
// Registered CORDIC cell chain, then the combine pipeline; one transfer per cycle while the output is not stalled.
// All stages advance together whenever the output register is free or taken.
// Synchronous active-low reset clears the valid chain only; input not ready in reset.
// A stalled output holds the whole pipeline; no transfer is lost.
`timescale 1ns / 1ps
`include "rotate_vector_about_axis_core_defines.svh"
module rotate_vector_about_axis_core #(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // vec_x[23:0] vec_y[47:24] vec_z[71:48] axis_x[89:72] axis_y[107:90]
    // axis_z[125:108] turn_angle[141:126] pad[143:142]
    input  logic [143:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // rot_x[23:0] rot_y[47:24] rot_z[71:48]
    output logic [71:0]  m_axis_tdata,
    // saturated[0]
    output logic         m_axis_tuser
);
    import rvaa_pkg::*;

    localparam int NST = (CORDIC_STAGES < TabLen) ? CORDIC_STAGES : TabLen;
    localparam int XW  = FRAC_BITS + 2;
    localparam longint X0 =
        (GainQ30 + (64'sd1 <<< (29 - FRAC_BITS))) >>> (30 - FRAC_BITS);

    logic                 en;
    logic                 c_vld  [NST+1];
    logic signed [XW-1:0] c_x    [NST+1];
    logic signed [XW-1:0] c_y    [NST+1];
    logic signed [ZW-1:0] c_z    [NST+1];
    logic [1:0]           c_quad [NST+1];
    t_geom                c_geom [NST+1];
    logic signed [VecW-1:0] rot_x, rot_y, rot_z;
    logic                 rot_at_limit;

    assign en            = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en && i_rst_n;

    assign c_vld[0]  = s_axis_tvalid;
    assign c_x[0]    = XW'(X0);
    assign c_y[0]    = '0;
    assign c_z[0]    = ZW'({s_axis_tdata[139:126], 16'h0000});
    assign c_quad[0] = s_axis_tdata[141:140];
    assign c_geom[0] = '{vec_x:  s_axis_tdata[23:0],
                         vec_y:  s_axis_tdata[47:24],
                         vec_z:  s_axis_tdata[71:48],
                         axis_x: s_axis_tdata[89:72],
                         axis_y: s_axis_tdata[107:90],
                         axis_z: s_axis_tdata[125:108]};

    for (genvar i = 0; i < NST; i++) begin : g_cell
        rvaa_cordic_cell #(.SHIFT(i), .XW(XW)) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_valid (c_vld[i]),
            .i_x     (c_x[i]),
            .i_y     (c_y[i]),
            .i_z     (c_z[i]),
            .i_quad  (c_quad[i]),
            .i_geom  (c_geom[i]),
            .o_valid (c_vld[i+1]),
            .o_x     (c_x[i+1]),
            .o_y     (c_y[i+1]),
            .o_z     (c_z[i+1]),
            .o_quad  (c_quad[i+1]),
            .o_geom  (c_geom[i+1])
        );
    end

    rvaa_math #(.FRAC_BITS(FRAC_BITS), .XW(XW)) u_math (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en),
        .i_valid     (c_vld[NST]),
        .i_x         (c_x[NST]),
        .i_y         (c_y[NST]),
        .i_quad      (c_quad[NST]),
        .i_geom      (c_geom[NST]),
        .o_valid     (m_axis_tvalid),
        .o_rot_x     (rot_x),
        .o_rot_y     (rot_y),
        .o_rot_z     (rot_z),
        .o_saturated (m_axis_tuser)
    );

    assign m_axis_tdata = {rot_z, rot_y, rot_x};

    assign rot_at_limit = (rot_x == 24'sh7FFFFF) || (rot_x == -24'sh800000)
                       || (rot_y == 24'sh7FFFFF) || (rot_y == -24'sh800000)
                       || (rot_z == 24'sh7FFFFF) || (rot_z == -24'sh800000);

    `RVAA_ASSERT_IMP(a_ready_follows_out, i_clk, i_rst_n, 1'b1, s_axis_tready == en)
    `RVAA_ASSERT_NXT(a_reset_clears_out, i_clk, !i_rst_n, !m_axis_tvalid)
    `RVAA_ASSERT_IMP(a_sat_at_limit, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, rot_at_limit)
endmodule
